FILE: sv/vboh_pkg.sv
// Package for the voxel occupancy histogram core.
// Holds payload structs, register indexes, grid constants and the sequencer state type.
// No dependencies.
package vboh_pkg;

  // Grid limits
  localparam int unsigned DIM_MAX  = 128;
  localparam int unsigned IDX_W    = $clog2(DIM_MAX);
  localparam int unsigned VOX_W    = 3 * IDX_W;
  localparam int unsigned DEPTH    = 1 << VOX_W;
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned PROD_W   = DIFF_W + SCALE_W;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z       = 3'd6;

  // Register reset values
  localparam logic signed [COORD_W-1:0] ORIGIN_RST      = -24'sd6400;
  localparam logic [SCALE_W-1:0]        INV_SPACING_RST = 24'd131072;
  localparam logic [DIM_W-1:0]          DIM_RST         = 8'd100;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic             in_grid;
    logic [VOX_W-1:0] voxel_index;
    logic [CNT_W-1:0] occupancy;
    logic [CNT_W-1:0] max_occupancy;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_LIN1,
    ST_LIN2,
    ST_READ,
    ST_UPD,
    ST_DONE
  } state_e;

  // Clamp a dimension register to the grid limit
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(DIM_MAX);
    return (d > lim) ? lim : d;
  endfunction

endpackage

FILE: sv/voxel_bin_occupancy_histogram_core.sv
// Top level of the voxel occupancy histogram core.
// Depends on vboh_pkg and vboh_ram.

// Each accepted position is turned into a voxel index and, when it falls
// inside the grid, that voxel's saturating count is incremented; one result
// per position. After reset the core sweeps the count memory to zero, one
// entry per cycle, before the first position is taken; register writes are
// taken throughout. A position then passes through these steps: one shared
// multiplier scales the three axes in turn, each followed by its range check,
// the row-major index is formed, and for a position inside the grid the count
// memory, with its registered read, is read and then written back. The result
// sits in an output register, so the next position is taken while an earlier
// result waits. Registers may be written only while no position is in
// flight.
module voxel_bin_occupancy_histogram_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  vboh_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vboh_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vboh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vboh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers
  logic signed [vboh_pkg::COORD_W-1:0] org_x_q, org_y_q, org_z_q;
  logic [vboh_pkg::SCALE_W-1:0]        inv_q;
  logic [vboh_pkg::DIM_W-1:0]          dim_x_q, dim_y_q, dim_z_q;

  // Sequencer and datapath
  vboh_pkg::state_e                    state_q, state_d;
  logic [vboh_pkg::VOX_W-1:0]          clr_q;
  logic [1:0]                          axis_q;
  vboh_pkg::in_item_t                  pos_q;
  logic [vboh_pkg::PROD_W-1:0]         prod_q;
  logic                                neg_q;
  logic [vboh_pkg::IDX_W-1:0]          idx_q [3];
  logic                                ok_q;
  logic [vboh_pkg::VOX_W-1:0]          lin_q;
  logic [vboh_pkg::VOX_W-1:0]          vox_q;
  logic [vboh_pkg::CNT_W-1:0]          peak_q;
  vboh_pkg::out_item_t                 res_q;
  logic                                out_valid_q;
  vboh_pkg::out_item_t                 out_q;

  logic                                in_fire;
  logic                                load_out;
  logic                                mem_we;
  logic [vboh_pkg::VOX_W-1:0]          mem_waddr;
  logic [vboh_pkg::CNT_W-1:0]          mem_wdata;
  logic [vboh_pkg::CNT_W-1:0]          mem_rdata;

  logic signed [vboh_pkg::COORD_W-1:0] sel_pos, sel_org;
  logic [vboh_pkg::DIM_W-1:0]          sel_dim;
  logic signed [vboh_pkg::DIFF_W-1:0]  diff;
  logic [vboh_pkg::DIFF_W-1:0]         mag;
  logic [vboh_pkg::DIFF_W-1:0]         quot;
  logic                                axis_ok;
  logic [vboh_pkg::CNT_W-1:0]          cnt_new;
  logic [vboh_pkg::CNT_W-1:0]          peak_new;
  logic [vboh_pkg::DIM_W-1:0]          dy_eff, dz_eff;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign dy_eff      = vboh_pkg::eff_dim(dim_y_q);
  assign dz_eff      = vboh_pkg::eff_dim(dim_z_q);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= vboh_pkg::ORIGIN_RST;
      org_y_q <= vboh_pkg::ORIGIN_RST;
      org_z_q <= vboh_pkg::ORIGIN_RST;
      inv_q   <= vboh_pkg::INV_SPACING_RST;
      dim_x_q <= vboh_pkg::DIM_RST;
      dim_y_q <= vboh_pkg::DIM_RST;
      dim_z_q <= vboh_pkg::DIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vboh_pkg::CFG_ORIGIN_X:    org_x_q <= cfg_data_i;
        vboh_pkg::CFG_ORIGIN_Y:    org_y_q <= cfg_data_i;
        vboh_pkg::CFG_ORIGIN_Z:    org_z_q <= cfg_data_i;
        vboh_pkg::CFG_INV_SPACING: inv_q   <= cfg_data_i;
        vboh_pkg::CFG_DIM_X:       dim_x_q <= cfg_data_i[vboh_pkg::DIM_W-1:0];
        vboh_pkg::CFG_DIM_Y:       dim_y_q <= cfg_data_i[vboh_pkg::DIM_W-1:0];
        vboh_pkg::CFG_DIM_Z:       dim_z_q <= cfg_data_i[vboh_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the axis under work
  always_comb begin
    unique case (axis_q)
      2'd0: begin
        sel_pos = pos_q.pos_x;
        sel_org = org_x_q;
        sel_dim = vboh_pkg::eff_dim(dim_x_q);
      end
      2'd1: begin
        sel_pos = pos_q.pos_y;
        sel_org = org_y_q;
        sel_dim = dy_eff;
      end
      default: begin
        sel_pos = pos_q.pos_z;
        sel_org = org_z_q;
        sel_dim = dz_eff;
      end
    endcase
  end

  // Offset from the origin and its magnitude
  assign diff = vboh_pkg::DIFF_W'(sel_pos) - vboh_pkg::DIFF_W'(sel_org);
  assign mag  = diff[vboh_pkg::DIFF_W-1] ? vboh_pkg::DIFF_W'(-diff) : diff;

  // Truncated index and range check on the registered product
  assign quot    = prod_q[vboh_pkg::PROD_W-1:vboh_pkg::SCALE_W];
  assign axis_ok = !(neg_q && (quot != '0)) &&
                   (quot < vboh_pkg::DIFF_W'(sel_dim));

  // Saturating increment and running maximum
  assign cnt_new  = (mem_rdata == vboh_pkg::CNT_SAT) ? mem_rdata : mem_rdata + 1'b1;
  assign peak_new = (cnt_new > peak_q) ? cnt_new : peak_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vboh_pkg::ST_CLEAR: if (clr_q == '1) state_d = vboh_pkg::ST_IDLE;
      vboh_pkg::ST_IDLE:  if (in_valid_i) state_d = vboh_pkg::ST_MUL;
      vboh_pkg::ST_MUL:   state_d = vboh_pkg::ST_CHK;
      vboh_pkg::ST_CHK:   state_d = (axis_q == 2'd2) ? vboh_pkg::ST_LIN1 : vboh_pkg::ST_MUL;
      vboh_pkg::ST_LIN1:  state_d = vboh_pkg::ST_LIN2;
      vboh_pkg::ST_LIN2:  state_d = ok_q ? vboh_pkg::ST_READ : vboh_pkg::ST_DONE;
      vboh_pkg::ST_READ:  state_d = vboh_pkg::ST_UPD;
      vboh_pkg::ST_UPD:   state_d = vboh_pkg::ST_DONE;
      vboh_pkg::ST_DONE:  if (!out_valid_q || out_ready_i) state_d = vboh_pkg::ST_IDLE;
      default:            state_d = vboh_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = vox_q;
    mem_wdata  = cnt_new;
    unique case (state_q)
      vboh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      vboh_pkg::ST_IDLE: in_ready_o = 1'b1;
      vboh_pkg::ST_UPD:  mem_we = 1'b1;
      vboh_pkg::ST_DONE: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // State, sweep counter, axis counter, peak and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vboh_pkg::ST_CLEAR;
      clr_q       <= '0;
      axis_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vboh_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_fire) begin
        axis_q <= '0;
      end else if (state_q == vboh_pkg::ST_CHK) begin
        axis_q <= axis_q + 1'b1;
      end
      if (state_q == vboh_pkg::ST_UPD) begin
        peak_q <= peak_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= in_data_i;
      ok_q  <= 1'b1;
    end
    // Scale one axis
    if (state_q == vboh_pkg::ST_MUL) begin
      prod_q <= vboh_pkg::PROD_W'(mag) * vboh_pkg::PROD_W'(inv_q);
      neg_q  <= diff[vboh_pkg::DIFF_W-1];
    end
    // Keep the axis index and fold in its range check
    if (state_q == vboh_pkg::ST_CHK) begin
      idx_q[axis_q] <= quot[vboh_pkg::IDX_W-1:0];
      ok_q          <= ok_q && axis_ok;
    end
    // Row-major index in two multiply steps
    if (state_q == vboh_pkg::ST_LIN1) begin
      lin_q <= vboh_pkg::VOX_W'(idx_q[0]) * vboh_pkg::VOX_W'(dy_eff) +
               vboh_pkg::VOX_W'(idx_q[1]);
    end
    if (state_q == vboh_pkg::ST_LIN2) begin
      vox_q <= lin_q * vboh_pkg::VOX_W'(dz_eff) + vboh_pkg::VOX_W'(idx_q[2]);
      res_q.in_grid       <= 1'b0;
      res_q.voxel_index   <= '0;
      res_q.occupancy     <= '0;
      res_q.max_occupancy <= peak_q;
    end
    if (state_q == vboh_pkg::ST_UPD) begin
      res_q.in_grid       <= 1'b1;
      res_q.voxel_index   <= vox_q;
      res_q.occupancy     <= cnt_new;
      res_q.max_occupancy <= peak_new;
    end
    // Hand the result to the output register
    if (load_out) begin
      out_q <= res_q;
    end
  end

  // Count store
  vboh_ram #(
    .WIDTH (vboh_pkg::CNT_W),
    .DEPTH (vboh_pkg::DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (vox_q),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: sv/vboh_ram.sv
// Simple dual-port synchronous RAM for the voxel count store.
// One write port, one read port with registered read data. No dependencies.
module vboh_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
